// ===== rtl/vgc_pkg.sv =====
// ----------------------------------------------------------------------------
// vgc_pkg
// Shared constants, codes and types of the visibility gain correction block.
// ----------------------------------------------------------------------------
package vgc_pkg;

  localparam int unsigned DEF_MAX_RECEIVERS = 256;
  localparam int unsigned DEF_MAX_BASELINES = 32768;
  localparam int unsigned DEF_FRAC_BITS     = 16;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 15;
  localparam int unsigned RECV_W  = 8;
  localparam int unsigned PAIR_W  = 2 * RECV_W;
  localparam int unsigned GAIN_W  = 2 * DATA_W;
  localparam int unsigned COUNT_W = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBTRACT_MODEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_COUNT = 2'd1;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD_GAIN  = 2'd0,
    OP_LOAD_PAIR  = 2'd1,
    OP_VISIBILITY = 2'd2
  } op_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] m_re;
    logic signed [DATA_W-1:0] m_im;
    logic signed [DATA_W-1:0] v_re;
    logic signed [DATA_W-1:0] v_im;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
    logic [IDX_W-1:0]         used;
  } vis_job_t;

endpackage

// ===== rtl/vgc_if.sv =====
// ----------------------------------------------------------------------------
// vgc_in_if / vgc_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface vgc_in_if import vgc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic [IDX_W-1:0]         table_index;
  logic signed [DATA_W-1:0] value_re;
  logic signed [DATA_W-1:0] value_im;
  logic signed [DATA_W-1:0] model_re;
  logic signed [DATA_W-1:0] model_im;
  logic [RECV_W-1:0]        receiver_first;
  logic [RECV_W-1:0]        receiver_second;
  logic                     restart;

  modport source (
    output valid, operation, table_index, value_re, value_im, model_re, model_im,
           receiver_first, receiver_second, restart,
    input  ready
  );
  modport sink (
    input  valid, operation, table_index, value_re, value_im, model_re, model_im,
           receiver_first, receiver_second, restart,
    output ready
  );
endinterface

interface vgc_out_if import vgc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_re;
  logic signed [DATA_W-1:0] out_im;
  logic [IDX_W-1:0]         baseline_used;
  logic                     saturated;

  modport source (output valid, out_re, out_im, baseline_used, saturated, input ready);
  modport sink   (input  valid, out_re, out_im, baseline_used, saturated, output ready);
endinterface

// ===== rtl/vgc_ram.sv =====
// ----------------------------------------------------------------------------
// vgc_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module vgc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vgc_front.sv =====
// ----------------------------------------------------------------------------
// vgc_front
// Accepts items, performs table loads, runs the baseline counter and fetches
// the pair and both gains of each visibility before queuing it.
// ----------------------------------------------------------------------------
module vgc_front import vgc_pkg::*; #(
  parameter int unsigned MAX_RECEIVERS = DEF_MAX_RECEIVERS,
  parameter int unsigned MAX_BASELINES = DEF_MAX_BASELINES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  vgc_in_if.sink             vis_i,
  input  logic [COUNT_W-1:0] baseline_count_i,
  input  logic [QCNT_W-1:0]  q_count_i,
  output logic               push_o,
  output vis_job_t           job_o
);

  localparam int unsigned RX_AW  = $clog2(MAX_RECEIVERS);
  localparam int unsigned BL_AW  = (MAX_BASELINES > 1) ? $clog2(MAX_BASELINES) : 1;
  localparam int unsigned CNT_LIM = (MAX_BASELINES < 65536) ? MAX_BASELINES : 65536;
  localparam int unsigned CNT_W  = (CNT_LIM > 1) ? $clog2(CNT_LIM) : 1;
  localparam int unsigned RX_CODES = 2 ** RECV_W;

  typedef logic [RX_AW-1:0] rx_map_t [RX_CODES];

  function automatic rx_map_t build_rx_map();
    rx_map_t t;
    for (int i = 0; i < RX_CODES; i++) begin
      t[i] = RX_AW'(i % MAX_RECEIVERS);
    end
    return t;
  endfunction

  localparam rx_map_t RX_MAP = build_rx_map();

  logic [CNT_W-1:0] counter_q, counter_d;
  logic             s1_valid_q, s2_valid_q;
  vis_job_t         s1_job_q, s1_job_d, s2_job_q;

  logic [QCNT_W:0]  occ;
  logic             accept;
  op_e              op;
  logic             gain_we, pair_we;
  logic [16:0]      count_eff;
  logic [CNT_W-1:0] used;
  logic [CNT_W:0]   used_inc;

  logic [PAIR_W-1:0] pair_rdata;
  logic [GAIN_W-1:0] gain_a_rdata, gain_b_rdata;
  logic [RX_AW-1:0]  ra, rb;

  assign occ         = (QCNT_W + 1)'(q_count_i) + (QCNT_W + 1)'(s1_valid_q)
                     + (QCNT_W + 1)'(s2_valid_q);
  assign vis_i.ready = (32'(occ) < QDEPTH);
  assign accept      = vis_i.valid && vis_i.ready;
  assign op          = op_e'(vis_i.operation);

  always_comb begin
    count_eff = (baseline_count_i == '0) ? 17'd1 : {1'b0, baseline_count_i};
    if (32'(count_eff) > MAX_BASELINES) begin
      count_eff = 17'(MAX_BASELINES);
    end
    used = vis_i.restart ? '0 : counter_q;
    if (17'(used) >= count_eff) begin
      used = '0;
    end
    used_inc = (CNT_W + 1)'(used) + (CNT_W + 1)'(1);
  end

  always_comb begin
    gain_we   = 1'b0;
    pair_we   = 1'b0;
    counter_d = counter_q;
    s1_job_d  = '0;
    s1_job_d.m_re = vis_i.value_re;
    s1_job_d.m_im = vis_i.value_im;
    s1_job_d.v_re = vis_i.model_re;
    s1_job_d.v_im = vis_i.model_im;
    s1_job_d.used = IDX_W'(used);
    unique case (op)
      OP_LOAD_GAIN: begin
        gain_we = accept && (32'(vis_i.table_index) < MAX_RECEIVERS);
      end
      OP_LOAD_PAIR: begin
        pair_we = accept && (32'(vis_i.table_index) < MAX_BASELINES);
      end
      OP_VISIBILITY: begin
        if (accept) begin
          counter_d = (17'(used_inc) >= count_eff) ? '0 : CNT_W'(used_inc);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q  <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      counter_q  <= counter_d;
      s1_valid_q <= accept && (op == OP_VISIBILITY);
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_job_q <= s1_job_d;
    s2_job_q <= s1_job_q;
  end

  vgc_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_BASELINES)) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (pair_we),
    .waddr_i (BL_AW'(vis_i.table_index)),
    .wdata_i ({vis_i.receiver_first, vis_i.receiver_second}),
    .raddr_i (BL_AW'(used)),
    .rdata_o (pair_rdata)
  );

  assign ra = RX_MAP[pair_rdata[PAIR_W-1:RECV_W]];
  assign rb = RX_MAP[pair_rdata[RECV_W-1:0]];

  vgc_ram #(.WIDTH(GAIN_W), .DEPTH(MAX_RECEIVERS)) u_gain_a_ram (
    .clk_i   (clk_i),
    .we_i    (gain_we),
    .waddr_i (RX_AW'(vis_i.table_index)),
    .wdata_i ({vis_i.value_re, vis_i.value_im}),
    .raddr_i (ra),
    .rdata_o (gain_a_rdata)
  );

  vgc_ram #(.WIDTH(GAIN_W), .DEPTH(MAX_RECEIVERS)) u_gain_b_ram (
    .clk_i   (clk_i),
    .we_i    (gain_we),
    .waddr_i (RX_AW'(vis_i.table_index)),
    .wdata_i ({vis_i.value_re, vis_i.value_im}),
    .raddr_i (rb),
    .rdata_o (gain_b_rdata)
  );

  always_comb begin
    job_o      = s2_job_q;
    job_o.a_re = gain_a_rdata[GAIN_W-1:DATA_W];
    job_o.a_im = gain_a_rdata[DATA_W-1:0];
    job_o.b_re = gain_b_rdata[GAIN_W-1:DATA_W];
    job_o.b_im = gain_b_rdata[DATA_W-1:0];
  end

  assign push_o = s2_valid_q;

endmodule

// ===== rtl/vgc_queue.sv =====
// ----------------------------------------------------------------------------
// vgc_queue
// Short FIFO of fetched visibility jobs between front and back.
// ----------------------------------------------------------------------------
module vgc_queue import vgc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vis_job_t          job_i,
  input  logic              pop_i,
  output logic              valid_o,
  output vis_job_t          job_o,
  output logic [QCNT_W-1:0] count_o
);

  vis_job_t          entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries[wr_ptr_q] <= job_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign job_o   = entries[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ===== rtl/vgc_back.sv =====
// ----------------------------------------------------------------------------
// vgc_back
// Gain product, correction, model subtraction and saturation; five stages
// ending in the output register.
// ----------------------------------------------------------------------------
module vgc_back import vgc_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     subtract_i,
  input  logic     q_valid_i,
  input  vis_job_t job_i,
  output logic     pop_o,
  vgc_out_if.source res_o
);

  localparam int unsigned PW = 2 * DATA_W;
  localparam int unsigned SW = PW + 1;

  typedef struct packed {
    logic                     sat;
    logic signed [DATA_W-1:0] val;
  } fx_t;

  function automatic fx_t rnd_clip(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] r;
    fx_t                  f;
    r = (s + (SW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    f.sat = 1'b1;
    if (r > $signed({{(SW-DATA_W){1'b0}}, {1'b0, {(DATA_W-1){1'b1}}}})) begin
      f.val = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (r < $signed({{(SW-DATA_W){1'b1}}, {1'b1, {(DATA_W-1){1'b0}}}})) begin
      f.val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      f.sat = 1'b0;
      f.val = r[DATA_W-1:0];
    end
    return f;
  endfunction

  function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] p);
    return $signed({p[PW-1], p});
  endfunction

  logic en;
  logic p1_valid_q, p2_valid_q, p3_valid_q, p4_valid_q, out_valid_q;

  logic signed [PW-1:0]     p1_pr0_q, p1_pr1_q, p1_pr2_q, p1_pr3_q;
  logic signed [PW-1:0]     p3_pr0_q, p3_pr1_q, p3_pr2_q, p3_pr3_q;
  logic signed [DATA_W-1:0] p1_m_re_q, p1_m_im_q, p2_m_re_q, p2_m_im_q;
  logic signed [DATA_W-1:0] p1_v_re_q, p1_v_im_q, p2_v_re_q, p2_v_im_q;
  logic signed [DATA_W-1:0] p3_v_re_q, p3_v_im_q, p4_v_re_q, p4_v_im_q;
  logic [IDX_W-1:0]         p1_used_q, p2_used_q, p3_used_q, p4_used_q, out_used_q;
  logic signed [DATA_W-1:0] p2_g_re_q, p2_g_im_q, p4_c_re_q, p4_c_im_q;
  logic                     p2_sat_q, p3_sat_q, p4_sat_q, out_sat_q;
  logic signed [DATA_W-1:0] out_re_q, out_im_q;

  fx_t g_re, g_im, c_re, c_im, d_re, d_im;

  assign en    = !out_valid_q || res_o.ready;
  assign pop_o = en && q_valid_i;

  assign g_re = rnd_clip(ext(p1_pr0_q) + ext(p1_pr1_q));
  assign g_im = rnd_clip(ext(p1_pr2_q) - ext(p1_pr3_q));
  assign c_re = rnd_clip(ext(p3_pr0_q) - ext(p3_pr1_q));
  assign c_im = rnd_clip(ext(p3_pr2_q) + ext(p3_pr3_q));

  always_comb begin
    logic signed [DATA_W:0] dr, di;
    dr = $signed({p4_c_re_q[DATA_W-1], p4_c_re_q}) - $signed({p4_v_re_q[DATA_W-1], p4_v_re_q});
    di = $signed({p4_c_im_q[DATA_W-1], p4_c_im_q}) - $signed({p4_v_im_q[DATA_W-1], p4_v_im_q});
    d_re.sat = (dr[DATA_W] != dr[DATA_W-1]);
    d_im.sat = (di[DATA_W] != di[DATA_W-1]);
    d_re.val = d_re.sat ? {dr[DATA_W], {(DATA_W-1){~dr[DATA_W]}}} : dr[DATA_W-1:0];
    d_im.val = d_im.sat ? {di[DATA_W], {(DATA_W-1){~di[DATA_W]}}} : di[DATA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      p3_valid_q  <= 1'b0;
      p4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q  <= q_valid_i;
      p2_valid_q  <= p1_valid_q;
      p3_valid_q  <= p2_valid_q;
      p4_valid_q  <= p3_valid_q;
      out_valid_q <= p4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_pr0_q  <= PW'(job_i.a_re) * PW'(job_i.b_re);
      p1_pr1_q  <= PW'(job_i.a_im) * PW'(job_i.b_im);
      p1_pr2_q  <= PW'(job_i.a_im) * PW'(job_i.b_re);
      p1_pr3_q  <= PW'(job_i.a_re) * PW'(job_i.b_im);
      p1_m_re_q <= job_i.m_re;
      p1_m_im_q <= job_i.m_im;
      p1_v_re_q <= job_i.v_re;
      p1_v_im_q <= job_i.v_im;
      p1_used_q <= job_i.used;

      p2_g_re_q <= g_re.val;
      p2_g_im_q <= g_im.val;
      p2_sat_q  <= g_re.sat | g_im.sat;
      p2_m_re_q <= p1_m_re_q;
      p2_m_im_q <= p1_m_im_q;
      p2_v_re_q <= p1_v_re_q;
      p2_v_im_q <= p1_v_im_q;
      p2_used_q <= p1_used_q;

      p3_pr0_q  <= PW'(p2_m_re_q) * PW'(p2_g_re_q);
      p3_pr1_q  <= PW'(p2_m_im_q) * PW'(p2_g_im_q);
      p3_pr2_q  <= PW'(p2_m_re_q) * PW'(p2_g_im_q);
      p3_pr3_q  <= PW'(p2_m_im_q) * PW'(p2_g_re_q);
      p3_sat_q  <= p2_sat_q;
      p3_v_re_q <= p2_v_re_q;
      p3_v_im_q <= p2_v_im_q;
      p3_used_q <= p2_used_q;

      p4_c_re_q <= c_re.val;
      p4_c_im_q <= c_im.val;
      p4_sat_q  <= p3_sat_q | c_re.sat | c_im.sat;
      p4_v_re_q <= p3_v_re_q;
      p4_v_im_q <= p3_v_im_q;
      p4_used_q <= p3_used_q;

      if (subtract_i) begin
        out_re_q  <= d_re.val;
        out_im_q  <= d_im.val;
        out_sat_q <= p4_sat_q | d_re.sat | d_im.sat;
      end else begin
        out_re_q  <= p4_c_re_q;
        out_im_q  <= p4_c_im_q;
        out_sat_q <= p4_sat_q;
      end
      out_used_q <= p4_used_q;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.out_re        = out_re_q;
  assign res_o.out_im        = out_im_q;
  assign res_o.baseline_used = out_used_q;
  assign res_o.saturated     = out_sat_q;

endmodule

// ===== rtl/visibility_gain_correction_top.sv =====
// ----------------------------------------------------------------------------
// visibility_gain_correction_top
// Path: a visibility passes 2 table read stages, the job queue and 5 arithmetic
//   stages before its result is valid; loads produce no result.
// Throughput: one item per cycle while results are taken, set by the 4-entry job queue credit.
// Reset: baseline counter 0, subtract_model 1, baseline_count 1; gain and
//   pair tables are not cleared and hold garbage until written.
// ----------------------------------------------------------------------------
module visibility_gain_correction_top import vgc_pkg::*; #(
  parameter int unsigned MAX_RECEIVERS = DEF_MAX_RECEIVERS,
  parameter int unsigned MAX_BASELINES = DEF_MAX_BASELINES,
  parameter int unsigned FRAC_BITS     = DEF_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  vgc_in_if.sink                vis_i,
  vgc_out_if.source             res_o
);

  logic               subtract_q;
  logic [COUNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subtract_q <= 1'b1;
      count_q    <= COUNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SUBTRACT_MODEL: subtract_q <= cfg_data_i[0];
        CFG_BASELINE_COUNT: count_q    <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic              push;
  vis_job_t          push_job;
  logic              pop;
  logic              q_valid;
  vis_job_t          q_job;
  logic [QCNT_W-1:0] q_count;

  vgc_front #(
    .MAX_RECEIVERS (MAX_RECEIVERS),
    .MAX_BASELINES (MAX_BASELINES)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .vis_i            (vis_i),
    .baseline_count_i (count_q),
    .q_count_i        (q_count),
    .push_o           (push),
    .job_o            (push_job)
  );

  vgc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (q_job),
    .count_o (q_count)
  );

  vgc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .subtract_i (subtract_q),
    .q_valid_i  (q_valid),
    .job_i      (q_job),
    .pop_o      (pop),
    .res_o      (res_o)
  );

endmodule
